@@ rtl/rmps_pkg.sv @@
// ----------------------------------------------------------------------------
// rmps_pkg
// Shared types, constants and helper functions for the region map pixel shader.
// ----------------------------------------------------------------------------
`default_nettype none

package rmps_pkg;

  // Stream and configuration widths
  localparam int TDATA_W    = 88;
  localparam int OUT_W      = 32;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_OVERRIDE_MASK = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PALETTE_COUNT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BEACON_REGION = 2'd2;

  // Request kinds carried in tuser
  localparam logic CMD_SHADE = 1'b0;
  localparam logic CMD_WRITE = 1'b1;

  // Main palette depth; the active count is clamped to it
  localparam int PALETTE_DEPTH = 16;
  localparam logic [4:0] PAL_CLAMP = (PALETTE_DEPTH > 31) ? 5'd31 : 5'(PALETTE_DEPTH);

  // Default depth of the queue between front and back
  localparam int QUEUE_DEPTH = 4;

  // Colour table slots of the special colours
  localparam logic [4:0] SLOT_BORDER  = 5'd16;
  localparam logic [4:0] SLOT_CLICKED = 5'd17;
  localparam logic [4:0] SLOT_ACTIVE  = 5'd18;
  localparam logic [4:0] SLOT_WATER   = 5'd19;
  localparam logic [4:0] SLOT_LAND    = 5'd20;
  localparam logic [4:0] SLOT_UNKNOWN = 5'd21;
  localparam logic [4:0] SLOT_BEACON  = 5'd22;

  // Hatch patterns, picked by region mod 7
  localparam logic [2:0] PAT_DIAG  = 3'd0;
  localparam logic [2:0] PAT_ANTI  = 3'd1;
  localparam logic [2:0] PAT_PROD1 = 3'd2;
  localparam logic [2:0] PAT_PROD2 = 3'd3;
  localparam logic [2:0] PAT_ROWS  = 3'd4;
  localparam logic [2:0] PAT_COLS  = 3'd5;
  localparam logic [2:0] PAT_DOTS  = 3'd6;

  localparam logic [7:0] SHADE_DIM = 8'h20;

  // Remainder pipeline: 15-bit dividend, a few bits per stage
  localparam int DVD_W      = 15;
  localparam int STEP_BITS  = 5;
  localparam int DIV_STAGES = DVD_W / STEP_BITS;

  typedef struct packed {
    logic [3:0]        override_mask;
    logic [4:0]        palette_count;
    logic signed [15:0] beacon_region;
  } cfg_t;

  // Item travelling through the front pipeline
  typedef struct packed {
    logic             wr;
    logic             pal;
    logic             hatch;
    logic [4:0]       slot;
    logic [31:0]      value;
    logic [DVD_W-1:0] dvd;
    logic [4:0]       dvs;
    logic [5:0]       rem;
  } front_t;

  // Queue entry handed to the back
  typedef struct packed {
    logic        wr;
    logic        hatch;
    logic [4:0]  slot;
    logic [31:0] value;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  // One restoring remainder step
  function automatic logic [5:0] rem_step(logic [5:0] rem, logic b, logic [4:0] dvs);
    logic [5:0] t;
    t = {rem[4:0], b};
    if (t >= {1'b0, dvs}) t = t - {1'b0, dvs};
    return t;
  endfunction

  // STEP_BITS remainder steps, MSB of the dividend first
  function automatic front_t div_stage(front_t s);
    front_t r;
    r = s;
    for (int i = 0; i < STEP_BITS; i++) begin
      r.rem = rem_step(r.rem, r.dvd[DVD_W-1], r.dvs);
      r.dvd = {r.dvd[DVD_W-2:0], 1'b0};
    end
    return r;
  endfunction

  // Reduce a value up to 5 mod 3
  function automatic logic [1:0] mod3_small(logic [2:0] v);
    return (v >= 3'd3) ? 2'(v - 3'd3) : 2'(v);
  endfunction

  // 12-bit value mod 3 by summing base-4 digits
  function automatic logic [1:0] mod3_12(logic [11:0] v);
    logic [4:0] s1;
    logic [2:0] s2;
    logic [2:0] s3;
    s1 = 5'(v[1:0]) + 5'(v[3:2]) + 5'(v[5:4]) + 5'(v[7:6]) + 5'(v[9:8]) + 5'(v[11:10]);
    s2 = 3'(s1[4]) + 3'(s1[3:2]) + 3'(s1[1:0]);
    s3 = 3'(s2[2]) + 3'(s2[1:0]);
    return mod3_small(s3);
  endfunction

  // 16-bit value mod 7 by summing octal digits
  function automatic logic [2:0] mod7_16(logic [15:0] v);
    logic [5:0] s1;
    logic [3:0] s2;
    logic [3:0] s3;
    s1 = 6'(v[2:0]) + 6'(v[5:3]) + 6'(v[8:6]) + 6'(v[11:9]) + 6'(v[14:12]) + 6'(v[15]);
    s2 = 4'(s1[5:3]) + 4'(s1[2:0]);
    s3 = 4'(s2[3]) + 4'(s2[2:0]);
    return (s3 >= 4'd7) ? 3'(s3 - 4'd7) : 3'(s3);
  endfunction

  // Hatch test; truncating remainder, so negative non-multiples never hatch
  function automatic logic hatch_hit(logic signed [15:0] region, logic [11:0] x,
                                     logic [11:0] y);
    logic [15:0] mag;
    logic [2:0]  pat;
    logic [1:0]  mx;
    logic [1:0]  my;
    logic [1:0]  s3;
    logic [1:0]  p3;
    logic [3:0]  prod;
    logic [1:0]  xy4;
    logic        hit;
    mag  = region[15] ? 16'(-region) : 16'(region);
    pat  = mod7_16(mag);
    mx   = mod3_12(x);
    my   = mod3_12(y);
    s3   = mod3_small(3'(mx) + 3'(my));
    prod = 4'(mx) * 4'(my);
    p3   = mod3_small(prod[2:0]);
    xy4  = x[1:0] + y[1:0];
    hit  = 1'b0;
    if (!(region[15] && (pat != PAT_DIAG))) begin
      case (pat)
        PAT_DIAG:  hit = (mx == my);
        PAT_ANTI:  hit = (s3 == 2'd0);
        PAT_PROD1: hit = (p3 == 2'd1);
        PAT_PROD2: hit = (p3 == 2'd2);
        PAT_ROWS:  hit = (my == {1'b0, x[0]});
        PAT_COLS:  hit = (mx == {1'b0, y[0]});
        PAT_DOTS:  hit = !y[0] && (xy4 == 2'd0);
        default:   hit = 1'b0;
      endcase
    end
    return hit;
  endfunction

  // Dim each RGB channel with a floor at zero, clear alpha
  function automatic logic [31:0] darken(logic [31:0] c);
    logic [7:0] r;
    logic [7:0] g;
    logic [7:0] b;
    r = (c[23:16] < SHADE_DIM) ? 8'h00 : c[23:16] - SHADE_DIM;
    g = (c[15:8]  < SHADE_DIM) ? 8'h00 : c[15:8]  - SHADE_DIM;
    b = (c[7:0]   < SHADE_DIM) ? 8'h00 : c[7:0]   - SHADE_DIM;
    return {8'h00, r, g, b};
  endfunction

endpackage

`default_nettype wire

@@ rtl/rmps_front.sv @@
// ----------------------------------------------------------------------------
// rmps_front
// Accepts requests, holds the configuration, classifies each pixel and runs
// the palette remainder pipeline before handing commands to the queue.
// ----------------------------------------------------------------------------
`default_nettype none

module rmps_front (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           in_valid_i,
  output logic                                in_ready_o,
  input  wire logic                           in_cmd_i,
  input  wire logic [rmps_pkg::TDATA_W-1:0]   in_data_i,
  input  wire logic                           cfg_we_i,
  input  wire logic [rmps_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [rmps_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  wire rmps_pkg::q_stat_t              q_stat_i,
  output logic                                push_o,
  output rmps_pkg::cmd_t                      cmd_o
);
  import rmps_pkg::*;

  localparam int LAST = DIV_STAGES - 1;

  cfg_t cfg_q;

  logic signed [15:0] region;
  logic [11:0]        xpos;
  logic [11:0]        ypos;
  logic               border_flag;
  logic               selected_flag;
  logic               active_flag;
  logic               plain_flag;
  logic               blink_phase;
  logic [4:0]         entry_index;
  logic [31:0]        entry_value;

  logic [4:0] cnt;
  logic       hatch_ok;
  front_t     cls;
  front_t     stg_in [DIV_STAGES];
  front_t     stg_q  [DIV_STAGES];
  logic [DIV_STAGES-1:0] vld_q;
  logic       adv;

  // Field unpack
  assign region        = in_data_i[15:0];
  assign xpos          = in_data_i[27:16];
  assign ypos          = in_data_i[39:28];
  assign border_flag   = in_data_i[40];
  assign selected_flag = in_data_i[41];
  assign active_flag   = in_data_i[42];
  assign plain_flag    = in_data_i[43];
  assign blink_phase   = in_data_i[44];
  assign entry_index   = in_data_i[49:45];
  assign entry_value   = in_data_i[81:50];

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.override_mask <= 4'd7;
      cfg_q.palette_count <= 5'd11;
      cfg_q.beacon_region <= -16'sd1;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_OVERRIDE_MASK: cfg_q.override_mask <= cfg_data_i[3:0];
        REG_PALETTE_COUNT: cfg_q.palette_count <= cfg_data_i[4:0];
        REG_BEACON_REGION: cfg_q.beacon_region <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Effective palette count: zero acts as one, clamp to depth
  always_comb begin
    if (cfg_q.palette_count == 5'd0) begin
      cnt = 5'd1;
    end else if (cfg_q.palette_count > PAL_CLAMP) begin
      cnt = PAL_CLAMP;
    end else begin
      cnt = cfg_q.palette_count;
    end
  end

  assign hatch_ok = !(plain_flag || cfg_q.override_mask[3]) &&
                    hatch_hit(region, xpos, ypos);

  // Priority chain
  always_comb begin
    cls     = '0;
    cls.dvd = region[DVD_W-1:0];
    cls.dvs = cnt;
    if (in_cmd_i == CMD_WRITE) begin
      cls.wr    = 1'b1;
      cls.slot  = entry_index;
      cls.value = entry_value;
    end else if (border_flag && cfg_q.override_mask[0]) begin
      cls.slot = SLOT_BORDER;
    end else if ((region == cfg_q.beacon_region) && blink_phase) begin
      cls.slot  = SLOT_BEACON;
      cls.hatch = hatch_ok;
    end else if (selected_flag && cfg_q.override_mask[1]) begin
      cls.slot  = SLOT_CLICKED;
      cls.hatch = hatch_ok;
    end else if (active_flag && cfg_q.override_mask[2]) begin
      cls.slot  = SLOT_ACTIVE;
      cls.hatch = hatch_ok;
    end else if (region == -16'sd1) begin
      cls.slot = SLOT_WATER;
    end else if (region == -16'sd2) begin
      cls.slot = SLOT_LAND;
    end else if (region <= -16'sd3) begin
      cls.slot = SLOT_UNKNOWN;
    end else begin
      cls.pal   = 1'b1;
      cls.hatch = hatch_ok;
    end
  end

  // Whole remainder pipe stalls on a full queue with a valid last stage
  assign adv        = !vld_q[LAST] || !q_stat_i.full;
  assign in_ready_o = adv;
  assign push_o     = vld_q[LAST] && !q_stat_i.full;

  assign stg_in[0] = cls;
  for (genvar g = 1; g < DIV_STAGES; g++) begin : g_link
    assign stg_in[g] = stg_q[g-1];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv) begin
      vld_q <= {vld_q[DIV_STAGES-2:0], in_valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int i = 0; i < DIV_STAGES; i++) begin
        stg_q[i] <= div_stage(stg_in[i]);
      end
    end
  end

  // Palette pixels take the remainder as their slot
  always_comb begin
    cmd_o.wr    = stg_q[LAST].wr;
    cmd_o.hatch = stg_q[LAST].hatch;
    cmd_o.slot  = stg_q[LAST].pal ? stg_q[LAST].rem[4:0] : stg_q[LAST].slot;
    cmd_o.value = stg_q[LAST].value;
  end

endmodule

`default_nettype wire

@@ rtl/rmps_queue.sv @@
// ----------------------------------------------------------------------------
// rmps_queue
// Small command FIFO that decouples the front pipeline from the back.
// ----------------------------------------------------------------------------
`default_nettype none

module rmps_queue #(
  parameter int DEPTH = rmps_pkg::QUEUE_DEPTH
) (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           push_i,
  input  wire rmps_pkg::cmd_t cmd_i,
  input  wire logic           pop_i,
  output rmps_pkg::q_stat_t   stat_o,
  output rmps_pkg::cmd_t      head_o
);
  import rmps_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);

  cmd_t             mem_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q;
  logic [PTR_W-1:0] rd_ptr_q;
  logic [CNT_W-1:0] cnt_q;

  // Pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + PTR_W'(1);
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + PTR_W'(1);
      end
      case ({push_i, pop_i})
        2'b10:   cnt_q <= cnt_q + CNT_W'(1);
        2'b01:   cnt_q <= cnt_q - CNT_W'(1);
        default: cnt_q <= cnt_q;
      endcase
    end
  end

  // Entry storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= cmd_i;
    end
  end

  assign stat_o.full  = (cnt_q == CNT_W'(DEPTH));
  assign stat_o.empty = (cnt_q == '0);
  assign head_o       = mem_q[rd_ptr_q];

endmodule

`default_nettype wire

@@ rtl/rmps_back.sv @@
// ----------------------------------------------------------------------------
// rmps_back
// Executes queued commands: colour table writes, table lookup with optional
// hatch dimming, and the registered output stage.
// ----------------------------------------------------------------------------
`default_nettype none

module rmps_back (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire rmps_pkg::q_stat_t          q_stat_i,
  input  wire rmps_pkg::cmd_t             head_i,
  output logic                            pop_o,
  output logic                            out_valid_o,
  input  wire logic                       out_ready_i,
  output logic [rmps_pkg::OUT_W-1:0]      out_color_o
);
  import rmps_pkg::*;

  logic [31:0]      tbl_q [32];
  logic             out_valid_q;
  logic [OUT_W-1:0] out_color_q;
  logic             out_free;
  logic [31:0]      rd_color;
  logic [OUT_W-1:0] color_d;

  // Writes always drain; shades need a free output register
  assign out_free = !out_valid_q || out_ready_i;
  assign pop_o    = !q_stat_i.empty && (head_i.wr || out_free);

  // Colour table, cleared by reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 32; i++) begin
        tbl_q[i] <= '0;
      end
    end else if (pop_o && head_i.wr) begin
      tbl_q[head_i.slot] <= head_i.value;
    end
  end

  assign rd_color = tbl_q[head_i.slot];
  assign color_d  = head_i.hatch ? darken(rd_color) : rd_color;

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (pop_o && !head_i.wr) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o && !head_i.wr) begin
      out_color_q <= color_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_color_o = out_color_q;

endmodule

`default_nettype wire

@@ rtl/region_map_pixel_shader.sv @@
// ----------------------------------------------------------------------------
// region_map_pixel_shader
// Colours map pixels from region number, coordinates and flags using a
// 32-entry colour table loaded by write requests.
//
//   Channel   Direction  Handshake                 Payload
//   s_axis    in         s_axis_tvalid/tready      tuser: command; tdata: pixel
//   m_axis    out        m_axis_tvalid/tready      tdata: pixel_color
//   cfg       in         cfg_we_i (no ready)       cfg_idx_i, cfg_data_i
//
// One request per cycle until a stalled output fills the queue. A shade
// request loads remainder stage 0 at the accepting edge, then passes 2 more
// remainder stages, the queue and the output register.
// Reset clears the colour table and loads configuration defaults at once; no clearing pass.
// A stalled output fills the queue (QUEUE_DEPTH entries); s_axis_tready drops
// once the queue is full and the last remainder stage holds a request.
// Write requests drain from the queue without using the output.
// ----------------------------------------------------------------------------
`default_nettype none

module region_map_pixel_shader #(
  parameter int QUEUE_DEPTH = rmps_pkg::QUEUE_DEPTH
) (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             s_axis_tvalid,
  output logic                                  s_axis_tready,
  // tdata: region[15:0], xpos[27:16], ypos[39:28], border_flag[40],
  //        selected_flag[41], active_flag[42], plain_flag[43],
  //        blink_phase[44], entry_index[49:45], entry_value[81:50], zero pad
  input  wire logic [rmps_pkg::TDATA_W-1:0]     s_axis_tdata,
  // tuser: command[0]
  input  wire logic                             s_axis_tuser,
  output logic                                  m_axis_tvalid,
  input  wire logic                             m_axis_tready,
  // tdata: pixel_color[31:0]
  output logic [rmps_pkg::OUT_W-1:0]            m_axis_tdata,
  input  wire logic                             cfg_we_i,
  input  wire logic [rmps_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  wire logic [rmps_pkg::CFG_DATA_W-1:0]  cfg_data_i
);
  import rmps_pkg::*;

  q_stat_t q_stat;
  cmd_t    push_cmd;
  cmd_t    head_cmd;
  logic    push;
  logic    pop;

  rmps_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .in_cmd_i   (s_axis_tuser),
    .in_data_i  (s_axis_tdata),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .q_stat_i   (q_stat),
    .push_o     (push),
    .cmd_o      (push_cmd)
  );

  rmps_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .cmd_i  (push_cmd),
    .pop_i  (pop),
    .stat_o (q_stat),
    .head_o (head_cmd)
  );

  rmps_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_stat_i    (q_stat),
    .head_i      (head_cmd),
    .pop_o       (pop),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_color_o (m_axis_tdata)
  );

endmodule

`default_nettype wire

@@ rtl/rmps_checker.sv @@
// ----------------------------------------------------------------------------
// rmps_checker
// Port-level checks on the pixel shader's output stream and back-pressure.
// ----------------------------------------------------------------------------
`default_nettype none

module rmps_checker (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          s_axis_tready,
  input  wire logic                          m_axis_tvalid,
  input  wire logic                          m_axis_tready,
  input  wire logic [rmps_pkg::OUT_W-1:0]    m_axis_tdata
);

  // Stalled result stays offered
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("result dropped while stalled");

  // Stalled result keeps its colour
  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
    else $error("result changed while stalled");

  // Input back-pressure only follows a stalled output
  a_bp_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> $past(m_axis_tvalid && !m_axis_tready))
    else $error("input stalled without output back-pressure");

  // Output valid only drops after the result was taken
  a_out_taken: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(m_axis_tvalid) |-> $past(m_axis_tready))
    else $error("result withdrawn without handshake");

endmodule

bind region_map_pixel_shader rmps_checker u_rmps_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire
